### src/swcs_pkg.sv
// Shared types, codes and constants of the stop-and-wait connection sender.
package swcs_pkg;

   localparam int SEQ_BITS = 32;

   localparam int REQ_W    = 3;
   localparam int SFLAG_W  = 3;
   localparam int INDEX_W  = 16;
   localparam int FLAGS_W  = 7;
   localparam int NUM_W    = 32;
   localparam int STATE_W  = 3;
   localparam int STATUS_W = 3;
   localparam int RETRY_W  = 4;
   localparam int TICKS_W  = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK       = 3'd0,
      REQ_RX         = 3'd1,
      REQ_CONNECT    = 3'd2,
      REQ_SEGMENT    = 3'd3,
      REQ_DISCONNECT = 3'd4
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NONE    = 3'd0,
      ST_SENT    = 3'd1,
      ST_DONE    = 3'd2,
      ST_EXHAUST = 3'd3,
      ST_NOSYN   = 3'd4,
      ST_REJECT  = 3'd5,
      ST_RETX    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      CSR_RETRY_LIMIT = 2'd0,
      CSR_ACK_WAIT    = 2'd1,
      CSR_LINGER      = 2'd2
   } csr_index_type;

   localparam logic [FLAGS_W-1:0] F_SYN   = 7'h01;
   localparam logic [FLAGS_W-1:0] F_ACK   = 7'h02;
   localparam logic [FLAGS_W-1:0] F_FIN   = 7'h04;
   localparam logic [FLAGS_W-1:0] F_PKT   = 7'h08;
   localparam logic [FLAGS_W-1:0] F_START = 7'h10;
   localparam logic [FLAGS_W-1:0] F_END   = 7'h20;
   localparam logic [FLAGS_W-1:0] F_FILE  = 7'h40;

   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd10;
   localparam logic [TICKS_W-1:0] ACK_WAIT_RST    = 16'd100;
   localparam logic [TICKS_W-1:0] LINGER_RST      = 16'd400;

endpackage

### src/swcs_channels.sv
// Request and response channel interfaces of the connection sender.
interface swcs_req_if;
   import swcs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic [SFLAG_W-1:0]   seg_flags;
   logic [INDEX_W-1:0]   seg_index;
   logic [FLAGS_W-1:0]   rx_flags;
   logic [NUM_W-1:0]     rx_seq;
   logic [NUM_W-1:0]     rx_ack;
   logic                 rx_ok;

   modport source (output valid, req_type, seg_flags, seg_index, rx_flags, rx_seq, rx_ack,
                   rx_ok, input ready);
   modport sink   (input valid, req_type, seg_flags, seg_index, rx_flags, rx_seq, rx_ack,
                   rx_ok, output ready);
endinterface

interface swcs_rsp_if;
   import swcs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 tx_send;
   logic [FLAGS_W-1:0]   tx_flags;
   logic [NUM_W-1:0]     tx_seq;
   logic [NUM_W-1:0]     tx_ack;
   logic [INDEX_W-1:0]   tx_index;
   logic [STATE_W-1:0]   conn_state;
   logic [STATUS_W-1:0]  status;
   logic [RETRY_W-1:0]   retries;

   modport source  (output valid, tx_send, tx_flags, tx_seq, tx_ack, tx_index, conn_state,
                    status, retries, input ready);
   modport sink    (input valid, tx_send, tx_flags, tx_seq, tx_ack, tx_index, conn_state,
                    status, retries, output ready);
   modport monitor (input valid, ready, tx_send, tx_flags, tx_seq, tx_ack, tx_index,
                    conn_state, status, retries);
endinterface

### src/stop_and_wait_connection_sender_core.sv
// Stop-and-wait sender with connection state: one event per transaction, one response each.
// Every request transaction (tick, received header, connect, send segment, disconnect)
// produces exactly one response transaction carrying the header to send (if any), the
// connection state after the event and a status. Requests land in an input register,
// are evaluated by a single pass of compare-and-update logic against the connection
// registers, and the response is held in an output register, so the block accepts one
// request per clock when the response side is not stalled; a stalled response holds
// the pipeline. Configuration registers (retry limit at 0x0, ack wait ticks at 0x4,
// time-wait ticks at 0x8) are written over the APB port and should be changed only
// while no transaction is in flight.
module stop_and_wait_connection_sender_core (
   input  logic                            clock,
   input  logic                            reset,
   swcs_req_if.sink                        req_ch,
   swcs_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [swcs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [swcs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [swcs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import swcs_pkg::*;

   typedef enum logic [STATE_W-1:0] {
      LS_CLOSED   = 3'd0,
      LS_SYN_SENT = 3'd1,
      LS_ESTAB    = 3'd2,
      LS_FIN1     = 3'd3,
      LS_FIN2     = 3'd4,
      LS_TWAIT    = 3'd5
   } link_type;

   typedef enum logic [1:0] {
      WP_IDLE = 2'd0,
      WP_ACK  = 2'd1,
      WP_PEER = 2'd2,
      WP_TW   = 2'd3
   } phase_type;

   // configuration
   logic [RETRY_W-1:0] retry_limit_ff;
   logic [TICKS_W-1:0] ack_wait_ff;
   logic [TICKS_W-1:0] linger_ff;
   logic               csr_write;
   csr_index_type      csr_index;

   // input stage
   logic               s1_valid_ff;
   logic [REQ_W-1:0]   s1_req_ff;
   logic [SFLAG_W-1:0] s1_sflags_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic [FLAGS_W-1:0] s1_rflags_ff;
   logic [NUM_W-1:0]   s1_rseq_ff;
   logic [NUM_W-1:0]   s1_rack_ff;
   logic               s1_rok_ff;

   // connection state
   link_type            link_ff, link_in;
   phase_type           phase_ff, phase_in;
   logic [SEQ_BITS-1:0] next_seq_ff, next_seq_in;
   logic [FLAGS_W-1:0]  held_flags_ff, held_flags_in;
   logic [SEQ_BITS-1:0] held_seq_ff, held_seq_in;
   logic [INDEX_W-1:0]  held_index_ff, held_index_in;
   logic [TICKS_W-1:0]  elapsed_ff, elapsed_in;
   logic [RETRY_W-1:0]  retry_ff, retry_in;

   // response stage
   logic                rsp_valid_ff;
   logic                tx_send_ff, tx_send_in;
   logic [FLAGS_W-1:0]  tx_flags_ff, tx_flags_in;
   logic [SEQ_BITS-1:0] tx_seq_ff, tx_seq_in;
   logic [SEQ_BITS-1:0] tx_ack_ff, tx_ack_in;
   logic [INDEX_W-1:0]  tx_index_ff, tx_index_in;
   logic [STATE_W-1:0]  conn_state_ff;
   status_type          status_ff, status_in;
   logic [RETRY_W-1:0]  retries_ff;

   logic                advance;
   logic                evaluate;
   logic [TICKS_W-1:0]  el_tick;
   logic [SEQ_BITS-1:0] peer_ack;
   logic [FLAGS_W-1:0]  seg_fl;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         CSR_RETRY_LIMIT: prdata = CSR_DATA_W'(retry_limit_ff);
         CSR_ACK_WAIT:    prdata = CSR_DATA_W'(ack_wait_ff);
         CSR_LINGER:      prdata = CSR_DATA_W'(linger_ff);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= RETRY_LIMIT_RST;
         ack_wait_ff    <= ACK_WAIT_RST;
         linger_ff      <= LINGER_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RETRY_LIMIT: retry_limit_ff <= pwdata[RETRY_W-1:0];
            CSR_ACK_WAIT:    ack_wait_ff    <= pwdata[TICKS_W-1:0];
            CSR_LINGER:      linger_ff      <= pwdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign evaluate     = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         s1_req_ff    <= req_ch.req_type;
         s1_sflags_ff <= req_ch.seg_flags;
         s1_index_ff  <= req_ch.seg_index;
         s1_rflags_ff <= req_ch.rx_flags;
         s1_rseq_ff   <= req_ch.rx_seq;
         s1_rack_ff   <= req_ch.rx_ack;
         s1_rok_ff    <= req_ch.rx_ok;
      end
   end

   // ---------------- event evaluation ----------------
   assign peer_ack = s1_rseq_ff[SEQ_BITS-1:0] + 1'b1;

   always_comb begin
      seg_fl = F_PKT;
      if (s1_sflags_ff[0]) seg_fl = seg_fl | F_START;
      if (s1_sflags_ff[1]) seg_fl = seg_fl | F_FILE;
      if (s1_sflags_ff[2]) seg_fl = seg_fl | F_END;
   end

   always_comb begin
      link_in       = link_ff;
      phase_in      = phase_ff;
      next_seq_in   = next_seq_ff;
      held_flags_in = held_flags_ff;
      held_seq_in   = held_seq_ff;
      held_index_in = held_index_ff;
      elapsed_in    = elapsed_ff;
      retry_in      = retry_ff;
      tx_send_in    = 1'b0;
      tx_flags_in   = '0;
      tx_seq_in     = '0;
      tx_ack_in     = '0;
      tx_index_in   = '0;
      status_in     = ST_NONE;

      el_tick = elapsed_ff;
      if ((phase_ff == WP_ACK || phase_ff == WP_TW) && elapsed_ff != '1) begin
         el_tick = elapsed_ff + 1'b1;
      end

      unique case (req_code_type'(s1_req_ff))
         REQ_TICK: begin
            elapsed_in = el_tick;
            if (phase_ff == WP_ACK && el_tick >= ack_wait_ff) begin
               if (retry_ff >= retry_limit_ff) begin
                  phase_in = WP_IDLE;
                  if (link_ff == LS_SYN_SENT) begin
                     link_in   = LS_CLOSED;
                     status_in = ST_NOSYN;
                  end else begin
                     if (link_ff == LS_FIN1) link_in = LS_ESTAB;
                     status_in = ST_EXHAUST;
                  end
               end else begin
                  // resend the held packet
                  retry_in    = retry_ff + 1'b1;
                  elapsed_in  = '0;
                  tx_send_in  = 1'b1;
                  tx_flags_in = held_flags_ff;
                  tx_seq_in   = held_seq_ff;
                  tx_index_in = held_index_ff;
                  status_in   = ST_RETX;
               end
            end else if (phase_ff == WP_TW && el_tick >= linger_ff) begin
               link_in     = LS_CLOSED;
               phase_in    = WP_IDLE;
               next_seq_in = '0;
               status_in   = ST_DONE;
            end
         end
         REQ_RX: begin
            if (s1_rok_ff && phase_ff == WP_ACK) begin
               if ((s1_rflags_ff & F_ACK) != '0 &&
                   s1_rack_ff[SEQ_BITS-1:0] == held_seq_ff + 1'b1) begin
                  phase_in  = WP_IDLE;
                  status_in = ST_DONE;
                  if (link_ff == LS_SYN_SENT) begin
                     if ((s1_rflags_ff & F_SYN) != '0) begin
                        tx_send_in  = 1'b1;
                        tx_flags_in = F_ACK | F_PKT;
                        tx_seq_in   = next_seq_ff;
                        tx_ack_in   = peer_ack;
                        next_seq_in = next_seq_ff + 1'b1;
                        link_in     = LS_ESTAB;
                     end else begin
                        link_in   = LS_CLOSED;
                        status_in = ST_NOSYN;
                     end
                  end else if (link_ff == LS_FIN1) begin
                     link_in  = LS_FIN2;
                     phase_in = WP_PEER;
                  end
               end
            end else if (s1_rok_ff && phase_ff == WP_PEER) begin
               // acknowledge whatever the peer sends, then enter time-wait
               tx_send_in  = 1'b1;
               tx_flags_in = F_ACK | F_PKT;
               tx_seq_in   = next_seq_ff;
               tx_ack_in   = peer_ack;
               next_seq_in = next_seq_ff + 1'b1;
               link_in     = LS_TWAIT;
               phase_in    = WP_TW;
               elapsed_in  = '0;
               status_in   = ST_SENT;
            end
         end
         REQ_CONNECT, REQ_SEGMENT, REQ_DISCONNECT: begin
            status_in = ST_REJECT;
            if (s1_req_ff == REQ_DISCONNECT && link_ff == LS_CLOSED && phase_ff == WP_IDLE) begin
               status_in = ST_DONE;
            end else if (phase_ff == WP_IDLE &&
                         ((s1_req_ff == REQ_CONNECT && link_ff == LS_CLOSED) ||
                          (s1_req_ff != REQ_CONNECT && link_ff == LS_ESTAB))) begin
               // hold and send a new packet
               unique case (req_code_type'(s1_req_ff))
                  REQ_CONNECT: begin
                     held_flags_in = F_SYN | F_PKT;
                     held_index_in = '0;
                     link_in       = LS_SYN_SENT;
                  end
                  REQ_SEGMENT: begin
                     held_flags_in = seg_fl;
                     held_index_in = s1_index_ff;
                  end
                  default: begin
                     held_flags_in = F_FIN | F_PKT;
                     held_index_in = '0;
                     link_in       = LS_FIN1;
                  end
               endcase
               held_seq_in = next_seq_ff;
               next_seq_in = next_seq_ff + 1'b1;
               phase_in    = WP_ACK;
               elapsed_in  = '0;
               retry_in    = '0;
               tx_send_in  = 1'b1;
               tx_flags_in = held_flags_in;
               tx_seq_in   = next_seq_ff;
               tx_index_in = held_index_in;
               status_in   = ST_SENT;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff       <= LS_CLOSED;
         phase_ff      <= WP_IDLE;
         next_seq_ff   <= '0;
         held_flags_ff <= '0;
         held_seq_ff   <= '0;
         held_index_ff <= '0;
         elapsed_ff    <= '0;
         retry_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (evaluate) begin
            link_ff       <= link_in;
            phase_ff      <= phase_in;
            next_seq_ff   <= next_seq_in;
            held_flags_ff <= held_flags_in;
            held_seq_ff   <= held_seq_in;
            held_index_ff <= held_index_in;
            elapsed_ff    <= elapsed_in;
            retry_ff      <= retry_in;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
      if (evaluate) begin
         tx_send_ff    <= tx_send_in;
         tx_flags_ff   <= tx_flags_in;
         tx_seq_ff     <= tx_seq_in;
         tx_ack_ff     <= tx_ack_in;
         tx_index_ff   <= tx_index_in;
         conn_state_ff <= link_in;
         status_ff     <= status_in;
         retries_ff    <= retry_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.tx_send    = tx_send_ff;
   assign rsp_ch.tx_flags   = tx_flags_ff;
   assign rsp_ch.tx_seq     = NUM_W'(tx_seq_ff);
   assign rsp_ch.tx_ack     = NUM_W'(tx_ack_ff);
   assign rsp_ch.tx_index   = tx_index_ff;
   assign rsp_ch.conn_state = conn_state_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.retries    = retries_ff;

endmodule

### src/swcs_checker.sv
// Port-level checks on the response channel of the connection sender.
module swcs_checker (
   input logic        clock,
   input logic        reset,
   swcs_rsp_if.source rsp_ch
);
   import swcs_pkg::*;

   // no header sent: header fields read zero
   a_idle_header_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.tx_send |->
         rsp_ch.tx_flags == '0 && rsp_ch.tx_seq == '0 && rsp_ch.tx_ack == '0 &&
         rsp_ch.tx_index == '0)
      else $error("header fields nonzero without a send");

   a_packet_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.tx_send |-> (rsp_ch.tx_flags & F_PKT) != '0)
      else $error("sent header lacks the packet flag");

   a_reject_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.status == ST_REJECT || rsp_ch.status == ST_EXHAUST ||
                       rsp_ch.status == ST_NOSYN) |-> !rsp_ch.tx_send)
      else $error("header sent with a failure status");

   a_ack_number: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.tx_flags & F_ACK) == '0 |-> rsp_ch.tx_ack == '0)
      else $error("acknowledgement number without ACK flag");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         rsp_ch.valid && $stable(rsp_ch.status) && $stable(rsp_ch.tx_seq) &&
         $stable(rsp_ch.conn_state))
      else $error("stalled transaction changed");

endmodule

bind stop_and_wait_connection_sender_core swcs_checker u_swcs_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_ch (rsp_ch)
);
